FILE: sv/sxp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sxp_pkg;

    localparam int GROUP_N = 7;
    localparam int NCFG    = 6;
    localparam int HDR_N   = 7;
    localparam int CFG_IDX_W = 3;

    localparam logic [7:0] SX_START = 8'hF0;
    localparam logic [7:0] SX_END   = 8'hF7;

    typedef logic [NCFG-1:0][6:0] t_cfg;

    localparam t_cfg CFG_RESET = {7'h00, 7'h05, 7'h01, 7'h02, 7'h03, 7'h7D};

    typedef struct packed {
        logic                   hdr;
        logic [2:0]             grp_n;
        logic [6:0]             prefix;
        logic [GROUP_N-1:0][6:0] data;
        logic                   trl;
    } t_desc;

endpackage

`default_nettype wire

FILE: sv/sxp_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module sxp_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output sxp_pkg::t_cfg      o_cfg
);
    import sxp_pkg::*;

    t_cfg                 r_cfg;
    logic [CFG_IDX_W-1:0] w_idx;
    logic                 w_hit;

    assign w_idx  = paddr[4:2];
    assign w_hit  = (w_idx < CFG_IDX_W'(NCFG));
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        prdata = '0;
        if (w_hit) begin
            prdata = {25'b0, r_cfg[w_idx]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (psel && penable && pwrite && pready && w_hit) begin
            r_cfg[w_idx] <= pwdata[6:0];
        end
    end

endmodule

`default_nettype wire

FILE: sv/sxp_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sxp_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    input  wire logic        i_slot_free,
    output logic             o_load,
    output sxp_pkg::t_desc   o_desc
);
    import sxp_pkg::*;

    logic                    r_in_valid;
    logic [7:0]              r_in_data;
    logic                    r_in_last;

    logic [GROUP_N-1:0][6:0] r_group_store;
    logic [6:0]              r_high_bits;
    logic [2:0]              r_fill_count;
    logic                    r_header_sent;

    logic [6:0]              n_high_bits;
    logic [2:0]              w_pos1;
    logic                    w_complete;
    logic                    w_produce;
    logic                    w_adv;

    assign n_high_bits = r_high_bits | ({6'b0, r_in_data[7]} << r_fill_count);
    assign w_pos1      = r_fill_count + 3'd1;
    assign w_complete  = (w_pos1 == 3'(GROUP_N)) || r_in_last;
    assign w_produce   = !r_header_sent || w_complete;
    assign w_adv       = r_in_valid && (!w_produce || i_slot_free);
    assign o_ready     = !r_in_valid || w_adv;
    assign o_load      = w_adv && w_produce;

    always_comb begin
        o_desc.hdr    = !r_header_sent;
        o_desc.grp_n  = w_complete ? w_pos1 : 3'd0;
        o_desc.prefix = n_high_bits;
        o_desc.trl    = r_in_last;
        for (int k = 0; k < GROUP_N; k++) begin
            o_desc.data[k] = (3'(k) == r_fill_count) ? r_in_data[6:0] : r_group_store[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_high_bits   <= '0;
            r_fill_count  <= '0;
            r_header_sent <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_adv) begin
                r_high_bits   <= w_complete ? 7'd0 : n_high_bits;
                r_fill_count  <= w_complete ? 3'd0 : w_pos1;
                r_header_sent <= !r_in_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_last_byte;
        end
        if (w_adv) begin
            r_group_store[r_fill_count] <= r_in_data[6:0];
        end
    end

endmodule

`default_nettype wire

FILE: sv/sxp_serializer.sv
`timescale 1ns / 1ps
`default_nettype none

module sxp_serializer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  sxp_pkg::t_desc     i_desc,
    input  sxp_pkg::t_cfg      i_cfg,
    output logic               o_slot_free,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_out_byte,
    output logic               o_run_end
);
    import sxp_pkg::*;

    logic       r_valid;
    t_desc      r_desc;
    logic [3:0] r_idx;
    logic [3:0] r_last_idx;

    logic [4:0] n_len;
    logic [3:0] w_j;
    logic       w_final;

    assign n_len = (i_desc.hdr ? 5'(HDR_N) : 5'd0)
                 + ((i_desc.grp_n != 3'd0) ? {2'b0, i_desc.grp_n} + 5'd1 : 5'd0)
                 + {4'b0, i_desc.trl};

    assign w_final     = (r_idx == r_last_idx);
    assign o_valid     = r_valid;
    assign o_run_end   = w_final;
    assign o_slot_free = !r_valid || (i_ready && w_final);
    assign w_j         = r_desc.hdr ? r_idx - 4'(HDR_N) : r_idx;

    always_comb begin
        if (r_desc.hdr && (r_idx < 4'(HDR_N))) begin
            if (r_idx == 4'd0) begin
                o_out_byte = SX_START;
            end else begin
                o_out_byte = {1'b0, i_cfg[3'(r_idx - 4'd1)]};
            end
        end else if ((r_desc.grp_n != 3'd0) && (w_j == 4'd0)) begin
            o_out_byte = {1'b0, r_desc.prefix};
        end else if (w_j <= {1'b0, r_desc.grp_n}) begin
            o_out_byte = {1'b0, r_desc.data[3'(w_j - 4'd1)]};
        end else begin
            o_out_byte = SX_END;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (r_valid && i_ready) begin
            if (w_final) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_desc     <= i_desc;
            r_last_idx <= 4'(n_len - 5'd1);
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_slot_free)
        else $error("descriptor loaded while previous request still pending");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx <= r_last_idx))
        else $error("byte index ran past end of descriptor");

    a_drop_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_ready && w_final && !i_load) |=> !r_valid)
        else $error("output stayed valid after final byte");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_idx)))
        else $error("byte index moved during stall");

endmodule

`default_nettype wire

FILE: sv/sysex_seven_bit_packer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake          Payload                      Direction
// input     i_valid / o_ready  i_data_byte, i_last_byte     in
// output    o_valid / i_ready  o_out_byte, o_run_end        out
// config    psel / penable     paddr, pwdata, prdata        APB
//
// One output byte per cycle while i_ready is high; a request that produces no bytes
// moves on without waiting, one that produces 3 to 10 bytes (set by the serializer)
// waits in the input register for a free slot, then loads the descriptor register.
// Reset is synchronous and active low; configuration returns to defaults.
// A stalled output holds its byte; input requests that produce no bytes still move on.

module sysex_seven_bit_packer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_run_end,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import sxp_pkg::*;

    t_cfg  w_cfg;
    t_desc w_desc;
    logic  w_load;
    logic  w_slot_free;

    sxp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sxp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_slot_free (w_slot_free),
        .o_load      (w_load),
        .o_desc      (w_desc)
    );

    sxp_serializer u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_desc      (w_desc),
        .i_cfg       (w_cfg),
        .o_slot_free (w_slot_free),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_run_end   (o_run_end)
    );

endmodule

`default_nettype wire

FILE: sim/tb_sysex_seven_bit_packer.sv
`timescale 1ns / 1ps

module tb_sysex_seven_bit_packer;

    import sxp_pkg::*;

    localparam int HOLD_OFF   = 4;
    localparam int MAX_BURST  = 16;
    localparam int PRINT_CAP  = 100;

    typedef enum logic [2:0] {
        REG_MANUFACTURER,
        REG_DEVICE,
        REG_MSG_TYPE,
        REG_VER_MAJOR,
        REG_VER_MINOR,
        REG_VER_POINT,
        REG_UNUSED_6,
        REG_UNUSED_7
    } sysex_reg_e;

    typedef struct packed {
        logic [7:0] value;
        logic       run_end;
    } sysex_byte_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_run_end;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [4:0]  paddr       = 5'd0;
    logic [31:0] pwdata      = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    sysex_seven_bit_packer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_run_end   (o_run_end),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // packer shadow state
    t_cfg        cfg_shadow = CFG_RESET;
    logic [6:0]  low7_group [GROUP_N];
    logic [6:0]  hi_bits    = 7'd0;
    int          fill_cnt   = 0;
    logic        hdr_done   = 1'b0;

    sysex_byte_t expected_q [$];
    int          mismatch_count = 0;
    int          result_idx     = 0;

    int          burst_left  = 1;
    int          tx_max_gap  = 0;
    logic        rx_free     = 1'b1;
    int          rx_hold     = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH %s at result %0d: got %0h expected %0h",
                     what, result_idx, got, want);
        mismatch_count++;
    endtask

    function automatic void pack_sysex_byte(input logic [7:0] b, input logic l);
        sysex_byte_t burst_out [MAX_BURST];
        int          n;
        int          pos;
        n   = 0;
        pos = fill_cnt;
        if (!hdr_done) begin
            burst_out[n] = {SX_START, 1'b0};
            n++;
            for (int r = 0; r < NCFG; r++) begin
                burst_out[n] = {1'b0, cfg_shadow[r], 1'b0};
                n++;
            end
            hdr_done = 1'b1;
        end
        if (pos >= GROUP_N) pos = 0;
        low7_group[pos] = b[6:0];
        if (b[7]) hi_bits[pos] = 1'b1;
        pos++;
        if (pos >= GROUP_N || l) begin
            burst_out[n] = {1'b0, hi_bits, 1'b0};
            n++;
            for (int k = 0; k < pos; k++) begin
                burst_out[n] = {1'b0, low7_group[k], 1'b0};
                n++;
            end
            hi_bits = 7'd0;
            pos     = 0;
        end
        fill_cnt = pos;
        if (l) begin
            burst_out[n] = {SX_END, 1'b0};
            n++;
            hdr_done = 1'b0;
        end
        if (n > 0) burst_out[n-1].run_end = 1'b1;
        for (int k = 0; k < n; k++) expected_q.push_back(burst_out[k]);
    endfunction

    always @(posedge i_clk) begin : result_check
        sysex_byte_t want;
        if (i_rst_n) begin
            if (i_valid && o_ready) pack_sysex_byte(i_data_byte, i_last_byte);
            if (o_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", {o_out_byte, o_run_end}, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (o_out_byte !== want.value)
                        report_mismatch("out_byte", o_out_byte, want.value);
                    if (o_run_end !== want.run_end)
                        report_mismatch("run_end", o_run_end, want.run_end);
                end
                result_idx++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (rx_free) begin
            i_ready <= 1'b1;
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else begin
            i_ready <= !i_ready;
            rx_hold <= i_ready ? $urandom_range(0, 5) : $urandom_range(0, 9);
        end
    end

    task automatic send_payload_byte(input logic [7:0] b, input logic l);
        int gap;
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= l;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(0, tx_max_gap);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic drain_results;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (HOLD_OFF) @(posedge i_clk);
    endtask

    task automatic apb_write(input sysex_reg_e idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (idx <= REG_VER_POINT) cfg_shadow[idx] = data[6:0];
    endtask

    task automatic cfg_readback_check;
        for (int r = 0; r < NCFG; r++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {r[2:0], 2'b00};
            @(posedge i_clk);
            penable <= 1'b1;
            @(negedge i_clk);
            if (prdata !== {25'd0, cfg_shadow[r]})
                report_mismatch("prdata", prdata, {25'd0, cfg_shadow[r]});
            @(posedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_message(input logic [7:0] msg [$]);
        for (int k = 0; k < msg.size(); k++)
            send_payload_byte(msg[k], k == msg.size() - 1);
    endtask

    task automatic test_reset_defaults;
        cfg_readback_check();
        send_message('{8'h00});
        drain_results();
    endtask

    task automatic test_directed_payloads;
        rx_free    <= 1'b0;
        tx_max_gap = 3;
        send_message('{8'hFF});
        send_message('{8'h80, 8'h00, 8'hFF, 8'h7F, 8'h01, 8'hFE, 8'h81, 8'h80});
        send_message('{8'h7F, 8'h80, 8'h55, 8'hAA, 8'h00, 8'hFF, 8'hC3});
        send_message('{8'h80, 8'h80});
        drain_results();
    endtask

    task automatic test_config_registers;
        for (int r = 0; r < NCFG; r++) apb_write(sysex_reg_e'(r), 32'd0);
        cfg_readback_check();
        send_message('{8'h12, 8'h93});
        drain_results();
        for (int r = 0; r < NCFG; r++) apb_write(sysex_reg_e'(r), 32'd127);
        cfg_readback_check();
        send_message('{8'hA5});
        drain_results();
        apb_write(REG_MANUFACTURER, 32'hFFFF_FF80);
        apb_write(REG_DEVICE, 32'hDEAD_BEEF);
        apb_write(REG_MSG_TYPE, 32'h0000_0100);
        apb_write(REG_UNUSED_6, 32'h0000_0011);
        apb_write(REG_UNUSED_7, 32'hFFFF_FFFF);
        cfg_readback_check();
        send_message('{8'h01, 8'h02, 8'h83});
        drain_results();
    endtask

    task automatic test_random_messages(input int target);
        int   sent;
        int   len;
        int   msgs;
        int   pick;
        logic l;
        sent = 0;
        msgs = 0;
        while (sent < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) len = $urandom_range(1, 9);
            else if (pick < 9) len = $urandom_range(10, 22);
            else len = $urandom_range(23, 40);
            rx_free    <= ($urandom_range(0, 3) == 0);
            tx_max_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                l = (k == len - 1) || ($urandom_range(0, 24) == 0);
                send_payload_byte(8'($urandom_range(0, 255)), l);
                sent++;
            end
            msgs++;
            if (msgs % 7 == 0) begin
                drain_results();
                apb_write(sysex_reg_e'($urandom_range(0, 7)), $urandom);
            end
        end
        drain_results();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed_payloads();
        test_config_registers();
        test_random_messages(240);
        if (expected_q.size() != 0)
            report_mismatch("results never arrived", expected_q.size(), 0);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
